@@ hdl/tun_pkg.sv @@
// Shared widths, constants and types of the triangle normal pipeline.
`default_nettype none

package tun_pkg;

  // Field and datapath widths
  localparam int IN_W     = 16;  // vertex coordinate, Q12.4
  localparam int DIFF_W   = 17;  // side vector component, Q13.4
  localparam int PROD_W   = 34;  // partial product of two side components
  localparam int CROSS_W  = 35;  // cross product component, signed
  localparam int MAG_W    = 33;  // magnitude of a cross product component
  localparam int POS_W    = 6;   // leading-one position of a magnitude
  localparam int NORM_POS = 29;  // leading one of the largest magnitude lands here
  localparam int NRM_W    = 30;  // normalized magnitude
  localparam int SQR_W    = 60;  // square of a normalized magnitude
  localparam int SQ_W     = 62;  // sum of squares
  localparam int ROOT_W   = 31;  // integer square root
  localparam int REM_W    = 32;  // square root partial remainder
  localparam int DIV_W    = 32;  // divisor and partial remainder of the divider
  localparam int QUO_W    = 15;  // quotient magnitude, up to 1.0 in Q1.14
  localparam int OUT_W    = 16;  // normal component, Q1.14

  // Pipeline depth of each unit
  localparam int CROSS_LAT = 3;
  localparam int SCALE_LAT = 5;
  localparam int SQRT_LAT  = ROOT_W;
  localparam int DIV_LAT   = QUO_W + 1;
  localparam int OUT_LAT   = 1;

  // One vertex
  typedef struct packed {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] z;
  } tun_vert_t;

  // Exact cross product
  typedef struct packed {
    logic signed [CROSS_W-1:0] x;
    logic signed [CROSS_W-1:0] y;
    logic signed [CROSS_W-1:0] z;
  } tun_cross_t;

  // Per-request flags carried to the output
  typedef struct packed {
    logic       degen;
    logic [2:0] neg;
  } tun_flag_t;

  // Data carried alongside the square root
  typedef struct packed {
    tun_flag_t             flag;
    logic [2:0][NRM_W-1:0] mag;
  } tun_side_t;

endpackage

`default_nettype wire

@@ hdl/tun_cross.sv @@
// Side vectors and exact cross product, three register stages.
`default_nettype none

module tun_cross (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  input  tun_pkg::tun_vert_t v1_i,
  input  tun_pkg::tun_vert_t v2_i,
  input  tun_pkg::tun_vert_t v3_i,
  output logic               vld_o,
  output tun_pkg::tun_cross_t c_o
);
  import tun_pkg::*;

  logic [CROSS_LAT-1:0]     vld_r;
  logic signed [DIFF_W-1:0] a_nxt [3];
  logic signed [DIFF_W-1:0] b_nxt [3];
  logic signed [DIFF_W-1:0] a_r   [3];
  logic signed [DIFF_W-1:0] b_r   [3];
  logic signed [PROD_W-1:0] prod_nxt [6];
  logic signed [PROD_W-1:0] prod_r   [6];
  tun_cross_t               c_nxt;
  tun_cross_t               c_r;

  // Valid bits follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[CROSS_LAT-2:0], vld_i};
    end
  end

  // Stage 1: A = v1 - v2, B = v2 - v3, sign extended so nothing overflows
  always_comb begin
    a_nxt[0] = {v1_i.x[IN_W-1], v1_i.x} - {v2_i.x[IN_W-1], v2_i.x};
    a_nxt[1] = {v1_i.y[IN_W-1], v1_i.y} - {v2_i.y[IN_W-1], v2_i.y};
    a_nxt[2] = {v1_i.z[IN_W-1], v1_i.z} - {v2_i.z[IN_W-1], v2_i.z};
    b_nxt[0] = {v2_i.x[IN_W-1], v2_i.x} - {v3_i.x[IN_W-1], v3_i.x};
    b_nxt[1] = {v2_i.y[IN_W-1], v2_i.y} - {v3_i.y[IN_W-1], v3_i.y};
    b_nxt[2] = {v2_i.z[IN_W-1], v2_i.z} - {v3_i.z[IN_W-1], v3_i.z};
  end

  // Stage 2: six signed 17x17 products
  always_comb begin
    prod_nxt[0] = a_r[1] * b_r[2];
    prod_nxt[1] = a_r[2] * b_r[1];
    prod_nxt[2] = a_r[2] * b_r[0];
    prod_nxt[3] = a_r[0] * b_r[2];
    prod_nxt[4] = a_r[0] * b_r[1];
    prod_nxt[5] = a_r[1] * b_r[0];
  end

  // Stage 3: differences of products
  always_comb begin
    c_nxt.x = {prod_r[0][PROD_W-1], prod_r[0]} - {prod_r[1][PROD_W-1], prod_r[1]};
    c_nxt.y = {prod_r[2][PROD_W-1], prod_r[2]} - {prod_r[3][PROD_W-1], prod_r[3]};
    c_nxt.z = {prod_r[4][PROD_W-1], prod_r[4]} - {prod_r[5][PROD_W-1], prod_r[5]};
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    prod_r <= prod_nxt;
    c_r    <= c_nxt;
  end

  assign vld_o = vld_r[CROSS_LAT-1];
  assign c_o   = c_r;

endmodule

`default_nettype wire

@@ hdl/tun_scale.sv @@
// Magnitudes, block normalization and sum of squares, five register stages.
`default_nettype none

module tun_scale (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    vld_i,
  input  tun_pkg::tun_cross_t     c_i,
  output logic                    vld_o,
  output logic [tun_pkg::SQ_W-1:0] s_o,
  output tun_pkg::tun_side_t      side_o
);
  import tun_pkg::*;

  logic [SCALE_LAT-1:0] vld_r;

  logic [MAG_W-1:0] magA_nxt [3];
  logic [MAG_W-1:0] magA_r   [3];
  logic [MAG_W-1:0] mxA_nxt;
  logic [MAG_W-1:0] mxA_r;
  logic [2:0]       negA_r;
  logic [2:0]       neg_nxt;
  logic signed [CROSS_W-1:0] comp [3];
  logic [CROSS_W-1:0]        absv [3];

  logic [MAG_W-1:0] magB_r [3];
  logic [POS_W-1:0] posB_nxt;
  logic [POS_W-1:0] posB_r;
  tun_flag_t        flagB_r;

  logic [POS_W-1:0] rsh;
  logic [POS_W-1:0] lsh;
  logic [MAG_W-1:0] shv  [3];
  logic [2:0][NRM_W-1:0] nrmC_nxt;
  logic [2:0][NRM_W-1:0] nrmC_r;
  tun_flag_t        flagC_r;

  logic [SQR_W-1:0] sqD_nxt [3];
  logic [SQR_W-1:0] sqD_r   [3];
  tun_side_t        sideD_r;

  logic [SQ_W-1:0]  sE_nxt;
  logic [SQ_W-1:0]  sE_r;
  tun_side_t        sideE_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SCALE_LAT-2:0], vld_i};
    end
  end

  // Stage A: absolute values, signs and the largest magnitude
  always_comb begin
    comp[0] = c_i.x;
    comp[1] = c_i.y;
    comp[2] = c_i.z;
    for (int i = 0; i < 3; i++) begin
      neg_nxt[i]  = comp[i][CROSS_W-1];
      absv[i]     = neg_nxt[i] ? CROSS_W'(-comp[i]) : CROSS_W'(comp[i]);
      magA_nxt[i] = absv[i][MAG_W-1:0];
    end
    mxA_nxt = (magA_nxt[0] > magA_nxt[1]) ? magA_nxt[0] : magA_nxt[1];
    if (magA_nxt[2] > mxA_nxt) begin
      mxA_nxt = magA_nxt[2];
    end
  end

  // Stage B: leading-one position of the largest magnitude
  always_comb begin
    posB_nxt = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mxA_r[i]) begin
        posB_nxt = POS_W'(i);
      end
    end
  end

  // Stage C: shift so the largest magnitude has its leading one at NORM_POS
  always_comb begin
    rsh = posB_r - POS_W'(NORM_POS);
    lsh = POS_W'(NORM_POS) - posB_r;
    for (int i = 0; i < 3; i++) begin
      if (posB_r >= POS_W'(NORM_POS)) begin
        shv[i] = magB_r[i] >> rsh;
      end else begin
        shv[i] = magB_r[i] << lsh;
      end
      nrmC_nxt[i] = shv[i][NRM_W-1:0];
    end
  end

  // Stage D: squares
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqD_nxt[i] = SQR_W'(nrmC_r[i]) * SQR_W'(nrmC_r[i]);
    end
  end

  // Stage E: sum of squares
  assign sE_nxt = SQ_W'(sqD_r[0]) + SQ_W'(sqD_r[1]) + SQ_W'(sqD_r[2]);

  always_ff @(posedge clk) begin
    magA_r        <= magA_nxt;
    mxA_r         <= mxA_nxt;
    negA_r        <= neg_nxt;
    magB_r        <= magA_r;
    posB_r        <= posB_nxt;
    flagB_r.degen <= (mxA_r == '0);
    flagB_r.neg   <= negA_r;
    nrmC_r        <= nrmC_nxt;
    flagC_r       <= flagB_r;
    sqD_r         <= sqD_nxt;
    sideD_r.flag  <= flagC_r;
    sideD_r.mag   <= nrmC_r;
    sE_r          <= sE_nxt;
    sideE_r       <= sideD_r;
  end

  assign vld_o  = vld_r[SCALE_LAT-1];
  assign s_o    = sE_r;
  assign side_o = sideE_r;

endmodule

`default_nettype wire

@@ hdl/tun_sqrt.sv @@
// Pipelined integer square root, one result bit per register stage.
`default_nettype none

module tun_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      vld_i,
  input  logic [tun_pkg::SQ_W-1:0]   s_i,
  input  tun_pkg::tun_side_t        side_i,
  output logic                      vld_o,
  output logic [tun_pkg::ROOT_W-1:0] root_o,
  output tun_pkg::tun_side_t        side_o
);
  import tun_pkg::*;

  // Stage k reads index k and drives index k+1
  logic [ROOT_W-1:0] root_p [SQRT_LAT+1];
  logic [REM_W-1:0]  rem_p  [SQRT_LAT+1];
  logic [SQ_W-1:0]   s_p    [SQRT_LAT+1];
  tun_side_t         side_p [SQRT_LAT+1];
  logic [SQRT_LAT:0] vld_p;

  assign root_p[0] = '0;
  assign rem_p[0]  = '0;
  assign s_p[0]    = s_i;
  assign side_p[0] = side_i;
  assign vld_p[0]  = vld_i;

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_step
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              ge;
    logic [ROOT_W-1:0] root_r;
    logic [REM_W-1:0]  rem_r;
    logic [SQ_W-1:0]   s_r;
    tun_side_t         side_r;
    logic              vld_r;

    // Bring down the next two bits and try a one in this root position
    assign rem_sh = {rem_p[k], s_p[k][SQ_W-1 -: 2]};
    assign trial  = {1'b0, root_p[k], 2'b01};
    assign ge     = (rem_sh >= trial);
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else begin
        vld_r <= vld_p[k];
      end
    end

    always_ff @(posedge clk) begin
      rem_r  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_r <= {root_p[k][ROOT_W-2:0], ge};
      s_r    <= {s_p[k][SQ_W-3:0], 2'b00};
      side_r <= side_p[k];
    end

    assign root_p[k+1] = root_r;
    assign rem_p[k+1]  = rem_r;
    assign s_p[k+1]    = s_r;
    assign side_p[k+1] = side_r;
    assign vld_p[k+1]  = vld_r;
  end

  assign vld_o  = vld_p[SQRT_LAT];
  assign root_o = root_p[SQRT_LAT];
  assign side_o = side_p[SQRT_LAT];

endmodule

`default_nettype wire

@@ hdl/tun_div.sv @@
// Pipelined rounded division m * 2^14 / r for three components, one bit per stage.
`default_nettype none

module tun_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             vld_i,
  input  logic [tun_pkg::ROOT_W-1:0]        root_i,
  input  tun_pkg::tun_side_t               side_i,
  output logic                             vld_o,
  output logic [2:0][tun_pkg::QUO_W-1:0]    q_o,
  output tun_pkg::tun_flag_t               flag_o
);
  import tun_pkg::*;

  // Prep stage: numerator (m * 2^15 + r) split into a head below 2r and tail bits
  logic [DIV_W-1:0]      d_r;
  logic [2:0][DIV_W-1:0] p0_nxt;
  logic [2:0][DIV_W-1:0] p0_r;
  logic [QUO_W-1:0]      low_r;
  tun_flag_t             flag_r;
  logic                  vld0_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p0_nxt[i] = DIV_W'(side_i.mag[i]) + DIV_W'(root_i[ROOT_W-1:QUO_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    d_r    <= {root_i, 1'b0};
    p0_r   <= p0_nxt;
    low_r  <= root_i[QUO_W-1:0];
    flag_r <= side_i.flag;
  end

  // Stage k reads index k and drives index k+1
  logic [2:0][DIV_W-1:0] p_p    [QUO_W+1];
  logic [2:0][QUO_W-1:0] q_p    [QUO_W+1];
  logic [DIV_W-1:0]      d_p    [QUO_W+1];
  logic [QUO_W-1:0]      low_p  [QUO_W+1];
  tun_flag_t             flag_p [QUO_W+1];
  logic [QUO_W:0]        vld_p;

  assign p_p[0]    = p0_r;
  assign q_p[0]    = '0;
  assign d_p[0]    = d_r;
  assign low_p[0]  = low_r;
  assign flag_p[0] = flag_r;
  assign vld_p[0]  = vld0_r;

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [DIV_W:0]        p_sh [3];
    logic [DIV_W:0]        diff [3];
    logic [2:0]            ge;
    logic [2:0][DIV_W-1:0] p_nxt;
    logic [2:0][QUO_W-1:0] q_nxt;
    logic [2:0][DIV_W-1:0] p_r;
    logic [2:0][QUO_W-1:0] q_r;
    logic [DIV_W-1:0]      d_sr;
    logic [QUO_W-1:0]      low_sr;
    tun_flag_t             flag_sr;
    logic                  vld_r;

    // Restoring step on each component
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        p_sh[i]  = {p_p[k][i], low_p[k][QUO_W-1]};
        diff[i]  = p_sh[i] - {1'b0, d_p[k]};
        ge[i]    = (p_sh[i] >= {1'b0, d_p[k]});
        p_nxt[i] = ge[i] ? diff[i][DIV_W-1:0] : p_sh[i][DIV_W-1:0];
        q_nxt[i] = {q_p[k][i][QUO_W-2:0], ge[i]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else begin
        vld_r <= vld_p[k];
      end
    end

    always_ff @(posedge clk) begin
      p_r     <= p_nxt;
      q_r     <= q_nxt;
      d_sr    <= d_p[k];
      low_sr  <= {low_p[k][QUO_W-2:0], 1'b0};
      flag_sr <= flag_p[k];
    end

    assign p_p[k+1]    = p_r;
    assign q_p[k+1]    = q_r;
    assign d_p[k+1]    = d_sr;
    assign low_p[k+1]  = low_sr;
    assign flag_p[k+1] = flag_sr;
    assign vld_p[k+1]  = vld_r;
  end

  assign vld_o  = vld_p[QUO_W];
  assign q_o    = q_p[QUO_W];
  assign flag_o = flag_p[QUO_W];

endmodule

`default_nettype wire

@@ hdl/triangle_unit_normal.sv @@
// Top level: unit surface normal of one triangle per request, fully pipelined.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  --------------------------
//  input     in_{first,second,third}_{x,y,z}         start high, busy low
//  result    out_normal_{x,y,z}, out_degenerate      out_valid, one cycle each
//
// Accepts one request every cycle while busy is low; each result passes in turn
// through the cross product, normalize and sum of squares, the bit-per-stage
// square root, the bit-per-stage divider and the output register.
// Reset (rst_n low, synchronous) clears all valid bits; busy is high during
// reset and for the cycle after it, then stays low.
// The receiver cannot stall; nothing in the pipeline ever stops.
`default_nettype none

module triangle_unit_normal (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [tun_pkg::IN_W-1:0]  in_first_x,
  input  logic signed [tun_pkg::IN_W-1:0]  in_first_y,
  input  logic signed [tun_pkg::IN_W-1:0]  in_first_z,
  input  logic signed [tun_pkg::IN_W-1:0]  in_second_x,
  input  logic signed [tun_pkg::IN_W-1:0]  in_second_y,
  input  logic signed [tun_pkg::IN_W-1:0]  in_second_z,
  input  logic signed [tun_pkg::IN_W-1:0]  in_third_x,
  input  logic signed [tun_pkg::IN_W-1:0]  in_third_y,
  input  logic signed [tun_pkg::IN_W-1:0]  in_third_z,
  output logic                            out_valid,
  output logic signed [tun_pkg::OUT_W-1:0] out_normal_x,
  output logic signed [tun_pkg::OUT_W-1:0] out_normal_y,
  output logic signed [tun_pkg::OUT_W-1:0] out_normal_z,
  output logic                            out_degenerate
);
  import tun_pkg::*;

  localparam int LATENCY = CROSS_LAT + SCALE_LAT + SQRT_LAT + DIV_LAT + OUT_LAT;
  localparam logic signed [OUT_W-1:0] ONE_Q14 = OUT_W'(1 << (QUO_W - 1));

  logic                  busy_r;
  logic                  in_vld;
  tun_vert_t             v1, v2, v3;

  logic                  cross_vld;
  tun_cross_t            cross_c;
  logic                  scale_vld;
  logic [SQ_W-1:0]       scale_s;
  tun_side_t             scale_side;
  logic                  sqrt_vld;
  logic [ROOT_W-1:0]     sqrt_root;
  tun_side_t             sqrt_side;
  logic                  div_vld;
  logic [2:0][QUO_W-1:0] div_q;
  tun_flag_t             div_flag;

  logic [2:0][OUT_W-1:0] nrm_nxt;
  logic [2:0][OUT_W-1:0] nrm_r;
  logic                  degen_r;
  logic                  out_valid_r;

  // Busy only while in reset and the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r || !rst_n;
  assign in_vld = start && !busy;

  assign v1 = '{x: in_first_x,  y: in_first_y,  z: in_first_z};
  assign v2 = '{x: in_second_x, y: in_second_y, z: in_second_z};
  assign v3 = '{x: in_third_x,  y: in_third_y,  z: in_third_z};

  tun_cross u_cross (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (in_vld),
    .v1_i  (v1),
    .v2_i  (v2),
    .v3_i  (v3),
    .vld_o (cross_vld),
    .c_o   (cross_c)
  );

  tun_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (cross_vld),
    .c_i    (cross_c),
    .vld_o  (scale_vld),
    .s_o    (scale_s),
    .side_o (scale_side)
  );

  tun_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (scale_vld),
    .s_i    (scale_s),
    .side_i (scale_side),
    .vld_o  (sqrt_vld),
    .root_o (sqrt_root),
    .side_o (sqrt_side)
  );

  tun_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (sqrt_vld),
    .root_i (sqrt_root),
    .side_i (sqrt_side),
    .vld_o  (div_vld),
    .q_o    (div_q),
    .flag_o (div_flag)
  );

  // Output stage: apply signs, force zero for a degenerate triangle
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (div_flag.degen) begin
        nrm_nxt[i] = '0;
      end else if (div_flag.neg[i]) begin
        nrm_nxt[i] = OUT_W'(-{1'b0, div_q[i]});
      end else begin
        nrm_nxt[i] = {1'b0, div_q[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    nrm_r   <= nrm_nxt;
    degen_r <= div_flag.degen;
  end

  assign out_valid      = out_valid_r;
  assign out_normal_x   = nrm_r[0];
  assign out_normal_y   = nrm_r[1];
  assign out_normal_z   = nrm_r[2];
  assign out_degenerate = degen_r;

  // Every result traces back to a request a fixed number of cycles earlier
  a_lat_back : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without matching request");

  // Degenerate results are the zero vector
  a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0))
    else $error("degenerate result not zero");

  // A real normal has a nonzero component
  a_nondegen_nz : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_degenerate) |->
      (out_normal_x != '0 || out_normal_y != '0 || out_normal_z != '0))
    else $error("normal of a real triangle is zero");

  // Components stay within plus or minus one
  a_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_normal_x <= ONE_Q14 && out_normal_x >= -ONE_Q14 &&
       out_normal_y <= ONE_Q14 && out_normal_y >= -ONE_Q14 &&
       out_normal_z <= ONE_Q14 && out_normal_z >= -ONE_Q14))
    else $error("normal component out of range");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for triangle_unit_normal: directed table plus random triangles.
`timescale 1ns / 100ps

module tb;
  import tun_pkg::*;

  localparam int N_RANDOM       = 900;
  localparam int DRAIN_CYCLES   = 80;    // pipeline is 56 deep
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no request and no result

  localparam logic signed [OUT_W-1:0] NRM_ZERO = '0;
  localparam logic signed [OUT_W-1:0] NRM_ONE  = 16'sd16384;
  localparam logic signed [OUT_W-1:0] NRM_MONE = -16'sd16384;

  // One expected (or observed) result
  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic                    degen;
  } normal_t;

  // One row of the directed table
  typedef struct {
    tun_vert_t v1;
    tun_vert_t v2;
    tun_vert_t v3;
    bit        typed;
    normal_t   want;
  } tri_case_t;

  logic      clk   = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  tun_vert_t v1    = '0;
  tun_vert_t v2    = '0;
  tun_vert_t v3    = '0;
  normal_t   cur_normal = '0;  // expectation for the request on the ports

  logic                    busy;
  logic                    out_valid;
  logic signed [OUT_W-1:0] out_normal_x;
  logic signed [OUT_W-1:0] out_normal_y;
  logic signed [OUT_W-1:0] out_normal_z;
  logic                    out_degenerate;

  normal_t   normals_due[$];
  int        err_cnt   = 0;
  int        idle_cnt  = 0;
  bit        no_gaps   = 1'b0;
  tri_case_t dir_tbl[$];

  always #2 clk = ~clk;

  triangle_unit_normal u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_first_x     (v1.x),
    .in_first_y     (v1.y),
    .in_first_z     (v1.z),
    .in_second_x    (v2.x),
    .in_second_y    (v2.y),
    .in_second_z    (v2.z),
    .in_third_x     (v3.x),
    .in_third_y     (v3.y),
    .in_third_z     (v3.z),
    .out_valid      (out_valid),
    .out_normal_x   (out_normal_x),
    .out_normal_y   (out_normal_y),
    .out_normal_z   (out_normal_z),
    .out_degenerate (out_degenerate)
  );

  // Digit-by-digit integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s    = s - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Exact cross product of the sides, then fixed-point scaling to unit length
  function automatic normal_t unit_normal(tun_vert_t p1, tun_vert_t p2, tun_vert_t p3);
    longint          a[3];
    longint          b[3];
    longint          c[3];
    longint unsigned m[3];
    longint unsigned mx;
    longint unsigned s;
    longint unsigned r;
    longint unsigned q;
    logic [OUT_W-1:0] n[3];
    normal_t         res;
    a[0] = longint'($signed(p1.x)) - longint'($signed(p2.x));
    a[1] = longint'($signed(p1.y)) - longint'($signed(p2.y));
    a[2] = longint'($signed(p1.z)) - longint'($signed(p2.z));
    b[0] = longint'($signed(p2.x)) - longint'($signed(p3.x));
    b[1] = longint'($signed(p2.y)) - longint'($signed(p3.y));
    b[2] = longint'($signed(p2.z)) - longint'($signed(p3.z));
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      res = '{NRM_ZERO, NRM_ZERO, NRM_ZERO, 1'b1};
      return res;
    end
    // bring the largest magnitude into [2^29, 2^30)
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      mx = mx >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      mx = mx << 1;
    end
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    r = int_sqrt(s);
    // round half up, sign follows the cross product
    for (int i = 0; i < 3; i++) begin
      q = (2 * m[i] * 16384 + r) / (2 * r);
      if (q > 16384) q = 16384;
      n[i] = (c[i] < 0) ? -q[OUT_W-1:0] : q[OUT_W-1:0];
    end
    res = '{n[0], n[1], n[2], 1'b0};
    return res;
  endfunction

  function automatic tun_vert_t vtx(int x, int y, int z);
    tun_vert_t p;
    p.x = x[IN_W-1:0];
    p.y = y[IN_W-1:0];
    p.z = z[IN_W-1:0];
    return p;
  endfunction

  function automatic tri_case_t tcase(tun_vert_t a, tun_vert_t b, tun_vert_t c,
                                      bit typed, normal_t want);
    tri_case_t t;
    t.v1    = a;
    t.v2    = b;
    t.v3    = c;
    t.typed = typed;
    t.want  = want;
    return t;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(tri_case_t t);
    dir_tbl.insert(dir_tbl.size(), t);
  endfunction

  // Random coordinate biased toward the extremes of the field and the values around zero
  function automatic int edge_coord();
    case ($urandom_range(0, 5))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return -1;
      4:       return 1;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  // Drive one request and hold it until accepted, then idle a random gap unless no_gaps is set
  task automatic send_triangle(tun_vert_t a, tun_vert_t b, tun_vert_t c, normal_t want);
    int gap;
    v1         <= a;
    v2         <= b;
    v3         <= c;
    cur_normal <= want;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the input until every pending result has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (normals_due.size() != 0);
  endtask

  // Result check, request capture and watchdog, all on the same edge
  always @(posedge clk) begin : result_check
    normal_t due;
    normal_t got;
    bit      took;
    took = 1'b0;
    if (rst_n && out_valid) begin
      took = 1'b1;
      got  = '{out_normal_x, out_normal_y, out_normal_z, out_degenerate};
      if (normals_due.size() == 0) begin
        $display("%0t: result with no request pending: x=%0d y=%0d z=%0d degen=%0b",
                 $time, got.x, got.y, got.z, got.degen);
        err_cnt++;
      end else begin
        due = normals_due.pop_front();
        if (got.x !== due.x) begin
          $display("%0t: normal_x expected %0d got %0d", $time, due.x, got.x);
          err_cnt++;
        end
        if (got.y !== due.y) begin
          $display("%0t: normal_y expected %0d got %0d", $time, due.y, got.y);
          err_cnt++;
        end
        if (got.z !== due.z) begin
          $display("%0t: normal_z expected %0d got %0d", $time, due.z, got.z);
          err_cnt++;
        end
        if (got.degen !== due.degen) begin
          $display("%0t: degenerate expected %0b got %0b", $time, due.degen, got.degen);
          err_cnt++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      took = 1'b1;
      normals_due.insert(normals_due.size(), cur_normal);
    end
    idle_cnt = took ? 0 : idle_cnt + 1;
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results pending", $time, normals_due.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    tun_vert_t a;
    tun_vert_t b;
    tun_vert_t c;
    normal_t   want;
    int        kind;
    int        sel;

    // directed table: degenerate cases, each axis in both signs, extremes, rounding
    add_row(tcase(vtx(0, 0, 0), vtx(0, 0, 0), vtx(0, 0, 0), 1,
                  '{NRM_ZERO, NRM_ZERO, NRM_ZERO, 1'b1}));
    add_row(tcase(vtx(0, 16, 0), vtx(0, 0, 0), vtx(0, 0, -16), 1,
                  '{NRM_ONE, NRM_ZERO, NRM_ZERO, 1'b0}));
    add_row(tcase(vtx(0, 0, 16), vtx(0, 0, 0), vtx(-16, 0, 0), 1,
                  '{NRM_ZERO, NRM_ONE, NRM_ZERO, 1'b0}));
    add_row(tcase(vtx(16, 0, 0), vtx(0, 0, 0), vtx(0, -16, 0), 1,
                  '{NRM_ZERO, NRM_ZERO, NRM_ONE, 1'b0}));
    add_row(tcase(vtx(0, 16, 0), vtx(0, 0, 0), vtx(0, 0, 16), 1,
                  '{NRM_MONE, NRM_ZERO, NRM_ZERO, 1'b0}));
    add_row(tcase(vtx(0, 0, 16), vtx(0, 0, 0), vtx(16, 0, 0), 1,
                  '{NRM_ZERO, NRM_MONE, NRM_ZERO, 1'b0}));
    add_row(tcase(vtx(16, 0, 0), vtx(0, 0, 0), vtx(0, 16, 0), 1,
                  '{NRM_ZERO, NRM_ZERO, NRM_MONE, 1'b0}));
    // smallest nonzero cross product
    add_row(tcase(vtx(1, 0, 0), vtx(0, 0, 0), vtx(0, -1, 0), 1,
                  '{NRM_ZERO, NRM_ZERO, NRM_ONE, 1'b0}));
    // largest cross product, both signs
    add_row(tcase(vtx(32767, 32767, 0), vtx(-32768, 32767, 0), vtx(0, -32768, 0),
                  1, '{NRM_ZERO, NRM_ZERO, NRM_ONE, 1'b0}));
    add_row(tcase(vtx(-32768, 32767, 0), vtx(32767, 32767, 0), vtx(0, -32768, 0),
                  1, '{NRM_ZERO, NRM_ZERO, NRM_MONE, 1'b0}));
    // coincident and collinear vertices
    add_row(tcase(vtx(32767, 32767, 32767), vtx(32767, 32767, 32767),
                  vtx(32767, 32767, 32767), 1,
                  '{NRM_ZERO, NRM_ZERO, NRM_ZERO, 1'b1}));
    add_row(tcase(vtx(-32768, -32768, -32768), vtx(-32768, -32768, -32768),
                  vtx(-32768, -32768, -32768), 1,
                  '{NRM_ZERO, NRM_ZERO, NRM_ZERO, 1'b1}));
    add_row(tcase(vtx(1, 1, 1), vtx(2, 2, 2), vtx(3, 3, 3), 1,
                  '{NRM_ZERO, NRM_ZERO, NRM_ZERO, 1'b1}));
    add_row(tcase(vtx(100, -200, 300), vtx(-5, 7, 9000), vtx(100, -200, 300), 1,
                  '{NRM_ZERO, NRM_ZERO, NRM_ZERO, 1'b1}));
    // predicted rows
    add_row(tcase(vtx(16, 0, 0), vtx(0, 16, 0), vtx(0, 0, 16), 0, '0));
    add_row(tcase(vtx(3, 4, 0), vtx(0, 0, 0), vtx(0, 0, -5), 0, '0));
    add_row(tcase(vtx(32767, -32768, 32767), vtx(-32768, 32767, -32768),
                  vtx(32767, 32767, -32768), 0, '0));
    add_row(tcase(vtx(-32768, -32768, -32768), vtx(32767, 0, -1),
                  vtx(-1, 32767, 0), 0, '0));
    add_row(tcase(vtx(1, 2, 3), vtx(-4, 5, -6), vtx(7, -8, 9), 0, '0));
    add_row(tcase(vtx(-1, -1, -1), vtx(0, 1, -32768), vtx(32767, -2, 5), 0, '0));

    // reset
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[i]) begin
      want = dir_tbl[i].typed ? dir_tbl[i].want
                              : unit_normal(dir_tbl[i].v1, dir_tbl[i].v2, dir_tbl[i].v3);
      send_triangle(dir_tbl[i].v1, dir_tbl[i].v2, dir_tbl[i].v3, want);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      // alternate stretches of back-to-back requests with gappy ones
      if (n % 60 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      if (n == N_RANDOM / 2) drain_results();
      kind = $urandom_range(0, 9);
      a = tun_vert_t'(48'({$urandom, $urandom}));
      b = tun_vert_t'(48'({$urandom, $urandom}));
      c = tun_vert_t'(48'({$urandom, $urandom}));
      case (kind)
        4, 5: begin
          // small triangle around a random point
          b = vtx(int'($signed(a.x)) + $urandom_range(0, 127) - 64,
                  int'($signed(a.y)) + $urandom_range(0, 127) - 64,
                  int'($signed(a.z)) + $urandom_range(0, 127) - 64);
          c = vtx(int'($signed(a.x)) + $urandom_range(0, 127) - 64,
                  int'($signed(a.y)) + $urandom_range(0, 127) - 64,
                  int'($signed(a.z)) + $urandom_range(0, 127) - 64);
        end
        6: begin
          // two coincident vertices: zero cross product
          sel = $urandom_range(0, 2);
          if (sel == 0) b = a;
          else if (sel == 1) c = b;
          else c = a;
        end
        7: begin
          a = vtx(edge_coord(), edge_coord(), edge_coord());
          b = vtx(edge_coord(), edge_coord(), edge_coord());
          c = vtx(edge_coord(), edge_coord(), edge_coord());
        end
        8, 9: begin
          // triangle in an axis plane: two cross components vanish
          sel = $urandom_range(0, 2);
          if (sel == 0) begin
            b.x = a.x;
            c.x = a.x;
          end else if (sel == 1) begin
            b.y = a.y;
            c.y = a.y;
          end else begin
            b.z = a.z;
            c.z = a.z;
          end
        end
        default: ;
      endcase
      send_triangle(a, b, c, unit_normal(a, b, c));
    end

    // drain and let any stray result show up
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/tun_pkg.sv
hdl/tun_cross.sv
hdl/tun_scale.sv
hdl/tun_sqrt.sv
hdl/tun_div.sv
hdl/triangle_unit_normal.sv
tb/tb.sv
